FILE: hw/rtl/dofq_pkg.sv
package dofq_pkg;

	// Storage geometry. The ring depth is a power of two so pointers wrap naturally.
	localparam int QUEUE_DEPTH = 16;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int LVL_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int FRAME_W     = 64;
	localparam int CNT_W       = 32;
	localparam int CAP_W       = 5;
	localparam int OP_W        = 2;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 5;

	// Result word: frame, dropped flag, fill level and three counters, padded to bytes.
	localparam int RES_BITS = FRAME_W + 1 + LVL_W + 3 * CNT_W;
	localparam int TDATA_W  = ((RES_BITS + 7) / 8) * 8;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POLICY_MODE    = 1'b0,
		REG_QUEUE_CAPACITY = 1'b1
	} cfg_reg_t;

	localparam logic MODE_LATEST  = 1'b0;
	localparam logic MODE_BOUNDED = 1'b1;

	// Everything of a result except the frame, which arrives from the ring memory.
	typedef struct packed {
		logic             pop_valid;
		logic             dropped_now;
		logic [LVL_W-1:0] fill_level;
		logic [CNT_W-1:0] pushed_total;
		logic [CNT_W-1:0] popped_total;
		logic [CNT_W-1:0] dropped_total;
	} result_t;

endpackage

FILE: hw/rtl/drop_oldest_frame_queue.sv
// Frame descriptor queue with a drop-oldest policy.
// Input words arrive on s_axis: tuser carries the opcode (push, pop, clear) and
// tdata carries the frame descriptor stored by a push. Each accepted word gives
// exactly one result word on m_axis: tuser is the pop-valid flag, tdata holds
// the popped frame, the drop flag of this push, the fill level and the pushed,
// popped and dropped counters.
// The descriptors live in a 16-entry ring memory with a registered read.
// Pointers, fill level and counters are updated at the edge that accepts a word,
// so the next word sees them at once; one word is taken every cycle while the
// receiver keeps up. A result passes through the ring read and the read stage,
// then through the output register, before it appears on m_axis.
// When the receiver stalls, the output register holds its word, the read stage
// behind it holds one more, and s_axis_tready drops until the output moves.
// Reset clears pointers, fill level and counters, sets bounded mode with a
// capacity of 16 and empties both stages; the ring contents are not cleared.
// Configuration writes through cfg_we/cfg_index/cfg_data take effect at once
// and are meant for an idle block; software issues a clear after reconfiguring.
module drop_oldest_frame_queue
	import dofq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration write port.
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// Input words.
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [FRAME_W-1:0]    s_axis_tdata,  // [63:0] frame_data
	input  logic [OP_W-1:0]       s_axis_tuser,  // [1:0] opcode
	// Result words.
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [63:0] frame_out, [64] dropped_now, [69:65] fill_level, [101:70] pushed_total,
	// [133:102] popped_total, [165:134] dropped_total, [167:166] zero
	output logic [TDATA_W-1:0]    m_axis_tdata,
	output logic [0:0]            m_axis_tuser   // [0] pop_valid
);

	logic             mode_q;
	logic [CAP_W-1:0] cap_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [LVL_W-1:0] count_q;
	logic [CNT_W-1:0] push_cnt_q;
	logic [CNT_W-1:0] pop_cnt_q;
	logic [CNT_W-1:0] drop_cnt_q;

	logic             s1_valid_q;
	result_t          res_s1;
	logic             out_valid_q;
	result_t          out_res_q;
	logic [FRAME_W-1:0] out_frame_q;

	logic             accept;
	logic             out_free;
	opcode_t          op;
	logic [LVL_W-1:0] cap_eff;
	logic             bound_drop;
	logic [PTR_W-1:0] ptr_after_drop;
	logic [LVL_W-1:0] cnt_after_drop;

	logic [PTR_W-1:0] rd_ptr_d;
	logic [LVL_W-1:0] count_d;
	logic [CNT_W-1:0] push_cnt_d;
	logic [CNT_W-1:0] pop_cnt_d;
	logic [CNT_W-1:0] drop_cnt_d;
	logic             pop_hit;
	logic             drop_hit;
	logic             ram_we;
	logic [PTR_W-1:0] ram_waddr;
	logic             ram_re;
	logic [FRAME_W-1:0] ram_rdata;

	// Handshake: the read stage empties whenever the output register can take a word.
	assign out_free      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !s1_valid_q || out_free;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign op            = opcode_t'(s_axis_tuser);

	// Effective capacity: zero counts as one, values above the depth as the depth.
	always_comb begin
		if (cap_q == '0) begin
			cap_eff = LVL_W'(1);
		end else if (LVL_W'(cap_q) > LVL_W'(QUEUE_DEPTH)) begin
			cap_eff = LVL_W'(QUEUE_DEPTH);
		end else begin
			cap_eff = LVL_W'(cap_q);
		end
	end

	// Bounded push onto a full queue first retires the oldest entry.
	assign bound_drop     = (count_q >= cap_eff) && (count_q != '0);
	assign ptr_after_drop = bound_drop ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
	assign cnt_after_drop = bound_drop ? count_q - LVL_W'(1) : count_q;

	// Next state of pointer, fill level and counters, plus the ring access.
	always_comb begin
		rd_ptr_d   = rd_ptr_q;
		count_d    = count_q;
		push_cnt_d = push_cnt_q;
		pop_cnt_d  = pop_cnt_q;
		drop_cnt_d = drop_cnt_q;
		pop_hit    = 1'b0;
		drop_hit   = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = rd_ptr_q;
		ram_re     = 1'b0;
		unique case (op)
			OP_PUSH: begin
				push_cnt_d = push_cnt_q + CNT_W'(1);
				ram_we     = accept;
				if (mode_q == MODE_LATEST) begin
					drop_hit  = (count_q != '0);
					count_d   = LVL_W'(1);
					ram_waddr = rd_ptr_q;
				end else begin
					drop_hit  = bound_drop;
					rd_ptr_d  = ptr_after_drop;
					count_d   = cnt_after_drop + LVL_W'(1);
					ram_waddr = ptr_after_drop + cnt_after_drop[PTR_W-1:0];
				end
				if (drop_hit) begin
					drop_cnt_d = drop_cnt_q + CNT_W'(1);
				end
			end
			OP_POP: begin
				if (count_q != '0) begin
					pop_hit   = 1'b1;
					ram_re    = accept;
					rd_ptr_d  = rd_ptr_q + PTR_W'(1);
					count_d   = count_q - LVL_W'(1);
					pop_cnt_d = pop_cnt_q + CNT_W'(1);
				end
			end
			OP_CLEAR: begin
				rd_ptr_d = '0;
				count_d  = '0;
			end
			default: begin
			end
		endcase
	end

	// Ring of frame descriptors.
	dofq_ram #(
		.WIDTH (FRAME_W),
		.DEPTH (QUEUE_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (s_axis_tdata),
		.re    (ram_re),
		.raddr (rd_ptr_q),
		.rdata (ram_rdata)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_BOUNDED;
			cap_q  <= CAP_W'(QUEUE_DEPTH);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_POLICY_MODE:    mode_q <= cfg_data[0];
				REG_QUEUE_CAPACITY: cap_q  <= cfg_data[CAP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Queue state is committed at the accepting edge.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q   <= '0;
			count_q    <= '0;
			push_cnt_q <= '0;
			pop_cnt_q  <= '0;
			drop_cnt_q <= '0;
		end else if (accept) begin
			rd_ptr_q   <= rd_ptr_d;
			count_q    <= count_d;
			push_cnt_q <= push_cnt_d;
			pop_cnt_q  <= pop_cnt_d;
			drop_cnt_q <= drop_cnt_d;
		end
	end

	// Read stage: waits for the ring read data alongside the rest of the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (out_free) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1.pop_valid     <= pop_hit;
			res_s1.dropped_now   <= drop_hit;
			res_s1.fill_level    <= count_d;
			res_s1.pushed_total  <= push_cnt_d;
			res_s1.popped_total  <= pop_cnt_d;
			res_s1.dropped_total <= drop_cnt_d;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && s1_valid_q) begin
			out_res_q   <= res_s1;
			out_frame_q <= res_s1.pop_valid ? ram_rdata : '0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_res_q.pop_valid;
	assign m_axis_tdata  = TDATA_W'({out_res_q.dropped_total, out_res_q.popped_total,
		out_res_q.pushed_total, out_res_q.fill_level, out_res_q.dropped_now, out_frame_q});

	// The fill level never exceeds the ring depth.
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= LVL_W'(QUEUE_DEPTH))
		else $error("fill level above ring depth");

	// A pop never reports a drop.
	a_pop_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tdata[FRAME_W])
		else $error("pop result flags a drop");

	// A full read stage behind a stalled output blocks the input.
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && out_valid_q && !m_axis_tready |-> !s_axis_tready)
		else $error("input taken while both stages are full");

	// An accepted clear leaves the queue empty.
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		accept && op == OP_CLEAR |=> count_q == '0 && rd_ptr_q == '0)
		else $error("clear did not empty the queue");

endmodule

FILE: hw/rtl/dofq_ram.sv
module dofq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port and one registered read port; read data holds between reads.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
